[sv/mrpb_pkg.sv]
// Package for the Modbus request PDU builder: function codes, request kinds,
// the byte job that crosses the queue, and queue sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrpb_pkg;

    // Kind of an incoming request.
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_VALUE  = 1'b1;

    // Function codes and code ranges.
    localparam logic [7:0] FC_FIRST_SUPPORTED = 8'd1;
    localparam logic [7:0] FC_LAST_READ       = 8'd4;
    localparam logic [7:0] FC_LAST_SINGLE     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS      = 8'd16;

    // Byte counts of the jobs.
    localparam logic [2:0] JOB_LEN_ONE    = 3'd1;
    localparam logic [2:0] JOB_LEN_TWO    = 3'd2;
    localparam logic [2:0] JOB_LEN_SINGLE = 3'd5;
    localparam logic [2:0] JOB_LEN_MULTI  = 3'd6;

    // Multiple write in progress.
    typedef enum logic [1:0] {
        ACT_IDLE  = 2'd0,
        ACT_COILS = 2'd1,
        ACT_REGS  = 2'd2
    } act_t;

    // One job for the serializer: up to six bytes, sent from byte 0 upward.
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            last;
        logic            err;
    } job_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QUEUE_PTR_W:0] level;
    } queue_status_t;

endpackage

`default_nettype wire

[sv/mrpb_front.sv]
// Front end of the PDU builder: accepts requests, checks them, tracks the
// multiple write in progress and turns each request into a byte job.
// Depends on mrpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrpb_front
    import mrpb_pkg::*;
#(
    parameter int MAX_WRITE_VALUES = 123
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        req_type,
    input  wire logic [7:0]  func_code,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] item_count,
    input  wire logic [15:0] data_word,
    output logic             push,
    output job_t             job
);

    localparam int VL_W = $clog2(MAX_WRITE_VALUES + 1);

    act_t            act_reg, act_next;
    logic [VL_W-1:0] values_left_reg, values_left_next;
    logic [7:0]      coil_acc_reg, coil_acc_next;
    logic [2:0]      coil_pos_reg, coil_pos_next;

    logic            in_multi;
    logic            code_single;
    logic            code_read;
    logic            code_multi;
    logic            count_bad;
    logic            header_ok_multi;
    logic [VL_W-1:0] values_dec;
    logic            last_value;
    logic [7:0]      coil_merged;
    logic [2:0]      coil_pos_inc;
    logic [16:0]     coil_round;
    logic [7:0]      multi_nbytes;

    assign in_multi    = (act_reg == ACT_COILS) || (act_reg == ACT_REGS);
    assign code_single = (func_code >= FC_FIRST_SUPPORTED)
                         && (func_code <= FC_LAST_SINGLE);
    assign code_read   = code_single && (func_code <= FC_LAST_READ);
    assign code_multi  = (func_code == FC_WRITE_COILS)
                         || (func_code == FC_WRITE_REGS);
    assign count_bad   = (item_count == 16'd0)
                         || (item_count > 16'(MAX_WRITE_VALUES));
    assign header_ok_multi = code_multi && !count_bad;

    assign values_dec   = values_left_reg - VL_W'(1);
    assign last_value   = (values_dec == '0);
    assign coil_merged  = coil_acc_reg
                          | (8'(data_word != 16'd0) << coil_pos_reg);
    assign coil_pos_inc = coil_pos_reg + 3'd1;
    assign coil_round   = {1'b0, item_count} + 17'd7;
    assign multi_nbytes = (func_code == FC_WRITE_COILS) ? coil_round[10:3]
                                                        : {item_count[6:0], 1'b0};

    // Next state.
    always_comb
    begin
        act_next         = act_reg;
        values_left_next = values_left_reg;
        coil_acc_next    = coil_acc_reg;
        coil_pos_next    = coil_pos_reg;
        if (accept)
        begin
            if (req_type == REQ_HEADER)
            begin
                if (in_multi)
                begin
                    // A header in the middle of a write abandons that write.
                    act_next         = ACT_IDLE;
                    values_left_next = '0;
                    coil_acc_next    = '0;
                    coil_pos_next    = '0;
                end
                else if (!code_single && header_ok_multi)
                begin
                    act_next = (func_code == FC_WRITE_COILS) ? ACT_COILS : ACT_REGS;
                    values_left_next = VL_W'(item_count);
                    coil_acc_next    = '0;
                    coil_pos_next    = '0;
                end
            end
            else if (act_reg == ACT_COILS)
            begin
                values_left_next = values_dec;
                coil_pos_next    = coil_pos_inc;
                coil_acc_next    = ((coil_pos_inc == 3'd0) || last_value) ? 8'd0 : coil_merged;
                if (last_value)
                begin
                    act_next      = ACT_IDLE;
                    coil_pos_next = '0;
                end
            end
            else if (act_reg == ACT_REGS)
            begin
                values_left_next = values_dec;
                if (last_value)
                begin
                    act_next = ACT_IDLE;
                end
            end
        end
    end

    // Job built from the current request.
    always_comb
    begin
        push       = 1'b0;
        job.bytes  = '0;
        job.nbytes = JOB_LEN_ONE;
        job.last   = 1'b1;
        job.err    = 1'b1;
        if (accept)
        begin
            push = 1'b1;
            if (req_type == REQ_HEADER)
            begin
                if (!in_multi && code_single && !(code_read && item_count == 16'd0))
                begin
                    job.bytes[0] = func_code;
                    job.bytes[1] = start_address[15:8];
                    job.bytes[2] = start_address[7:0];
                    job.bytes[3] = code_read ? item_count[15:8] : data_word[15:8];
                    job.bytes[4] = code_read ? item_count[7:0] : data_word[7:0];
                    job.nbytes   = JOB_LEN_SINGLE;
                    job.err      = 1'b0;
                end
                else if (!in_multi && !code_single && header_ok_multi)
                begin
                    job.bytes[0] = func_code;
                    job.bytes[1] = start_address[15:8];
                    job.bytes[2] = start_address[7:0];
                    job.bytes[3] = item_count[15:8];
                    job.bytes[4] = item_count[7:0];
                    job.bytes[5] = multi_nbytes;
                    job.nbytes   = JOB_LEN_MULTI;
                    job.last     = 1'b0;
                    job.err      = 1'b0;
                end
            end
            else if (act_reg == ACT_COILS)
            begin
                // A coil byte leaves once eight coils are in or the write ends.
                push         = (coil_pos_inc == 3'd0) || last_value;
                job.bytes[0] = coil_merged;
                job.last     = last_value;
                job.err      = 1'b0;
            end
            else if (act_reg == ACT_REGS)
            begin
                job.bytes[0] = data_word[15:8];
                job.bytes[1] = data_word[7:0];
                job.nbytes   = JOB_LEN_TWO;
                job.last     = last_value;
                job.err      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg         <= ACT_IDLE;
            values_left_reg <= '0;
            coil_acc_reg    <= '0;
            coil_pos_reg    <= '0;
        end
        else
        begin
            act_reg         <= act_next;
            values_left_reg <= values_left_next;
            coil_acc_reg    <= coil_acc_next;
            coil_pos_reg    <= coil_pos_next;
        end
    end

endmodule

`default_nettype wire

[sv/mrpb_queue.sv]
// Short job queue between the front end and the serializer.
// Depends on mrpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrpb_queue
    import mrpb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output queue_status_t status
);

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   level_reg, level_next;

    assign head_job     = mem_reg[rd_ptr_reg];
    assign status.level = level_reg;
    assign status.full  = (level_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + (QUEUE_PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

[sv/mrpb_back.sv]
// Serializer: sends the bytes of the head job through an output
// register, one per cycle while out_stall is low. Depends on mrpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrpb_back
    import mrpb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire job_t  head_job,
    input  wire logic  queue_empty,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [7:0] pdu_byte,
    output logic       last_byte,
    output logic       error_flag
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;

    logic       load;
    logic       emit;
    logic       end_of_job;
    logic [7:0] sel_byte;

    assign load       = !valid_reg || !out_stall;
    assign emit       = load && !queue_empty;
    assign end_of_job = (idx_reg == head_job.nbytes - 3'd1);
    assign pop        = emit && end_of_job;

    always_comb
    begin
        case (idx_reg)
            3'd0:    sel_byte = head_job.bytes[0];
            3'd1:    sel_byte = head_job.bytes[1];
            3'd2:    sel_byte = head_job.bytes[2];
            3'd3:    sel_byte = head_job.bytes[3];
            3'd4:    sel_byte = head_job.bytes[4];
            3'd5:    sel_byte = head_job.bytes[5];
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            last_next  = end_of_job && head_job.last;
            err_next   = head_job.err;
            idx_next   = end_of_job ? 3'd0 : idx_reg + 3'd1;
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign out_valid  = valid_reg;
    assign pdu_byte   = byte_reg;
    assign last_byte  = last_reg;
    assign error_flag = err_reg;

endmodule

`default_nettype wire

[sv/modbus_request_pdu_builder_core.sv]
// Top level of the Modbus request PDU builder: front end, job queue and
// serializer. Depends on mrpb_pkg, mrpb_front, mrpb_queue and mrpb_back.
//
//   Channel | Handshake           | Contents
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | req_type, func_code, start_address,
//           |                     | item_count, data_word
//   out     | out_valid/out_stall | pdu_byte, last_byte, error_flag
//
// A request is taken whenever the job queue has room; its job is written into
// the queue and its bytes then leave through the output register one per cycle
// while the output is not stalled. The serializer sets the pace: a good header
// yields five or six bytes, an error result one, a register value two and a
// coil value at most one, so a coil stream runs at one request per cycle while
// the output is not stalled.
// Reset clears the multiple-write state, the queue pointers and the output
// valid; the block takes requests in the first cycle after reset.
// in_stall is high only while the four-entry queue is full; a stalled output
// holds its byte while the front end keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module modbus_request_pdu_builder_core
    import mrpb_pkg::*;
#(
    parameter int MAX_WRITE_VALUES = 123
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [7:0]  func_code,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] item_count,
    input  wire logic [15:0] data_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       pdu_byte,
    output logic             last_byte,
    output logic             error_flag
);

    logic          accept;
    logic          push;
    logic          pop;
    job_t          new_job;
    job_t          head_job;
    queue_status_t q_status;

    // The front end runs freely as long as the queue can take its job.
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // The front end checks each request and keeps the state of the multiple
    // write in progress; every request that yields bytes becomes one job.
    mrpb_front #(
        .MAX_WRITE_VALUES(MAX_WRITE_VALUES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (req_type),
        .func_code    (func_code),
        .start_address(start_address),
        .item_count   (item_count),
        .data_word    (data_word),
        .push         (push),
        .job          (new_job)
    );

    // The queue lets a slow consumer stall the serializer without stopping
    // the front end until it fills.
    mrpb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(new_job),
        .pop     (pop),
        .head_job(head_job),
        .status  (q_status)
    );

    // The serializer walks through the bytes of the head job.
    mrpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .queue_empty(q_status.empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pdu_byte   (pdu_byte),
        .last_byte  (last_byte),
        .error_flag (error_flag)
    );

    // An error result is always a single zero byte that closes its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_flag |-> last_byte && (pdu_byte == 8'd0))
        else $error("error result without last_byte or with a nonzero byte");

    // The serializer never retires a job from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job popped from an empty queue");

    // A full queue never takes another job.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !push)
        else $error("job pushed into a full queue");

    // The queue level rises by one after a push without a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> q_status.level == $past(q_status.level) + (QUEUE_PTR_W + 1)'(1))
        else $error("queue level did not follow a push");

endmodule

`default_nettype wire

[tb/sv/modbus_request_pdu_builder_core_test.sv]
// Self-checking testbench for modbus_request_pdu_builder_core: directed and random
// requests, a bit-exact predictor of the PDU byte stream, and a byte-by-byte checker.
// Depends on mrpb_pkg and the builder RTL.
`timescale 1ns / 1ps

module modbus_request_pdu_builder_core_test;
    import mrpb_pkg::*;

    localparam int MAX_WRITE_VALUES = 123;
    localparam int RESET_CYCLES     = 10;
    localparam int RANDOM_REQUESTS  = 200;
    localparam int DRAIN_CYCLES     = 24;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int REPORT_LIMIT     = 10;

    // Function codes by name; the package gives only the bounds and codes 15, 16.
    localparam logic [7:0] FC_READ_COILS        = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE     = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING      = 8'd3;
    localparam logic [7:0] FC_READ_INPUT        = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE_COIL = 8'd5;
    localparam logic [7:0] FC_WRITE_SINGLE_REG  = 8'd6;
    localparam logic [7:0] FC_UNASSIGNED        = 8'd0;
    localparam logic [7:0] FC_PAST_SINGLES      = 8'd7;
    localparam logic [7:0] FC_ALL_ONES          = 8'hFF;

    typedef enum int {
        STALL_NEVER,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } stall_style_t;

    typedef struct packed {
        logic [7:0] pdu;
        logic       last;
        logic       err;
    } pdu_beat_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic        req_type      = REQ_HEADER;
    logic [7:0]  func_code     = 8'd0;
    logic [15:0] start_address = 16'd0;
    logic [15:0] item_count    = 16'd0;
    logic [15:0] data_word     = 16'd0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [7:0]  pdu_byte;
    logic        last_byte;
    logic        error_flag;

    // Predictor copy of the multiple-write state.
    act_t        write_mode  = ACT_IDLE;
    logic [15:0] values_left = 16'd0;
    logic [7:0]  coil_byte   = 8'd0;
    logic [2:0]  coil_pos    = 3'd0;

    pdu_beat_t    pending_pdu_bytes[$];
    int           byte_mismatches = 0;
    int           requests_sent   = 0;
    int           burst_left      = 0;
    int           cycle_count     = 0;
    stall_style_t stall_style     = STALL_NEVER;
    int           stall_phase_left = 0;

    modbus_request_pdu_builder_core #(
        .MAX_WRITE_VALUES(MAX_WRITE_VALUES)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .func_code     (func_code),
        .start_address (start_address),
        .item_count    (item_count),
        .data_word     (data_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pdu_byte      (pdu_byte),
        .last_byte     (last_byte),
        .error_flag    (error_flag)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void push_byte(input logic [7:0] value, input logic last,
                                      input logic err);
        pdu_beat_t beat;
        beat.pdu  = value;
        beat.last = last;
        beat.err  = err;
        pending_pdu_bytes.push_back(beat);
    endfunction

    function automatic void push_error();
        push_byte(8'h00, 1'b1, 1'b1);
    endfunction

    function automatic void end_write();
        write_mode  = ACT_IDLE;
        values_left = 16'd0;
        coil_byte   = 8'd0;
        coil_pos    = 3'd0;
    endfunction

    // Works out the PDU bytes that one accepted request causes and queues them.
    function automatic void encode_request(input logic kind, input logic [7:0] code,
                                           input logic [15:0] addr,
                                           input logic [15:0] count,
                                           input logic [15:0] data);
        logic [7:0] fourth;
        logic [7:0] fifth;
        int         byte_total;
        logic       finished;
        if (kind == REQ_HEADER)
        begin
            if (write_mode == ACT_COILS || write_mode == ACT_REGS)
            begin
                // A header cuts off the unfinished write and is itself dropped.
                end_write();
                push_error();
            end
            else if (code >= FC_FIRST_SUPPORTED && code <= FC_LAST_SINGLE)
            begin
                if (code <= FC_LAST_READ && count == 16'd0)
                begin
                    push_error();
                end
                else
                begin
                    if (code <= FC_LAST_READ)
                    begin
                        fourth = count[15:8];
                        fifth  = count[7:0];
                    end
                    else
                    begin
                        fourth = data[15:8];
                        fifth  = data[7:0];
                    end
                    push_byte(code, 1'b0, 1'b0);
                    push_byte(addr[15:8], 1'b0, 1'b0);
                    push_byte(addr[7:0], 1'b0, 1'b0);
                    push_byte(fourth, 1'b0, 1'b0);
                    push_byte(fifth, 1'b1, 1'b0);
                end
            end
            else if (code != FC_WRITE_COILS && code != FC_WRITE_REGS)
            begin
                push_error();
            end
            else if (count == 16'd0 || count > 16'(MAX_WRITE_VALUES))
            begin
                push_error();
            end
            else
            begin
                if (code == FC_WRITE_COILS)
                    byte_total = (int'(count) + 7) / 8;
                else
                    byte_total = int'(count) * 2;
                push_byte(code, 1'b0, 1'b0);
                push_byte(addr[15:8], 1'b0, 1'b0);
                push_byte(addr[7:0], 1'b0, 1'b0);
                push_byte(count[15:8], 1'b0, 1'b0);
                push_byte(count[7:0], 1'b0, 1'b0);
                push_byte(byte_total[7:0], 1'b0, 1'b0);
                write_mode  = (code == FC_WRITE_COILS) ? ACT_COILS : ACT_REGS;
                values_left = count;
                coil_byte   = 8'd0;
                coil_pos    = 3'd0;
            end
        end
        else if (write_mode == ACT_COILS)
        begin
            // Coils pack LSB first; a byte leaves when full or on the last coil.
            if (data != 16'd0)
                coil_byte[coil_pos] = 1'b1;
            coil_pos    = coil_pos + 3'd1;
            values_left = values_left - 16'd1;
            finished    = (values_left == 16'd0);
            if (coil_pos == 3'd0 || finished)
            begin
                push_byte(coil_byte, finished, 1'b0);
                coil_byte = 8'd0;
                if (finished)
                    end_write();
            end
        end
        else if (write_mode == ACT_REGS)
        begin
            values_left = values_left - 16'd1;
            finished    = (values_left == 16'd0);
            push_byte(data[15:8], 1'b0, 1'b0);
            push_byte(data[7:0], finished, 1'b0);
            if (finished)
                end_write();
        end
        else
        begin
            push_error();
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Presents one request and holds it until taken. Valid stays high after
    // acceptance; the burst logic lowers it only when a gap is chosen.
    task automatic send_request(input logic kind, input logic [7:0] code,
                                input logic [15:0] addr, input logic [15:0] count,
                                input logic [15:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        req_type      <= kind;
        func_code     <= code;
        start_address <= addr;
        item_count    <= count;
        data_word     <= data;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        encode_request(kind, code, addr, count, data);
        requests_sent++;
    endtask

    // A value request carries junk in the header-only fields.
    task automatic send_value(input logic [15:0] data);
        send_request(REQ_VALUE, 8'($urandom), 16'($urandom), 16'($urandom), data);
    endtask

    // Header for code 15 or 16, then values with random content. Stopping at
    // stop_after < count leaves the write open for the next header to cut off.
    task automatic send_write_sequence(input logic [7:0] code, input int count,
                                       input int stop_after);
        logic [15:0] value;
        send_request(REQ_HEADER, code, 16'($urandom), 16'(count), 16'($urandom));
        for (int i = 0; i < stop_after; i++)
        begin
            if (code == FC_WRITE_COILS)
            begin
                case ($urandom_range(0, 3))
                    0:       value = 16'd0;
                    1:       value = 16'd1 << $urandom_range(0, 15);
                    default: value = 16'($urandom);
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       value = 16'h0000;
                    1:       value = 16'hFFFF;
                    default: value = 16'($urandom);
                endcase
            end
            send_value(value);
        end
    endtask

    // ------------------------------------------------------------------
    // Output checker and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_output
        pdu_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pdu_bytes.size() == 0)
            begin
                byte_mismatches++;
                if (byte_mismatches <= REPORT_LIMIT)
                    $display("unexpected byte %02h last %0b err %0b at cycle %0d",
                             pdu_byte, last_byte, error_flag, cycle_count);
            end
            else
            begin
                want = pending_pdu_bytes.pop_front();
                if (pdu_byte !== want.pdu || last_byte !== want.last
                        || error_flag !== want.err)
                begin
                    byte_mismatches++;
                    if (byte_mismatches <= REPORT_LIMIT)
                        $display("byte mismatch at cycle %0d: expected %02h last %0b ",
                                 cycle_count, want.pdu, want.last,
                                 "err %0b, got %02h last %0b err %0b",
                                 want.err, pdu_byte, last_byte, error_flag);
                end
            end
        end
    end

    // The receiver switches between stall styles at random.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_style      <= stall_style_t'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(16, 64);
        end
        else
        begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_style)
            STALL_NEVER:  out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
            default:      out_stall <= (cycle_count % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_read_requests();
        send_request(REQ_HEADER, FC_READ_COILS, 16'h0000, 16'h0001, 16'h0000);
        send_request(REQ_HEADER, FC_READ_INPUT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_HEADER, FC_READ_HOLDING, 16'h1234, 16'h007D, 16'hA5A5);
        // A read of zero items is refused.
        send_request(REQ_HEADER, FC_READ_DISCRETE, 16'h0042, 16'h0000, 16'h0000);
    endtask

    task automatic test_single_writes();
        // The count field plays no part in single writes.
        send_request(REQ_HEADER, FC_WRITE_SINGLE_COIL, 16'h00AC, 16'hFFFF, 16'hFF00);
        send_request(REQ_HEADER, FC_WRITE_SINGLE_REG, 16'hFFFF, 16'h0000, 16'h0000);
    endtask

    task automatic test_unknown_codes();
        send_request(REQ_HEADER, FC_UNASSIGNED, 16'h0001, 16'h0001, 16'h0001);
        send_request(REQ_HEADER, FC_PAST_SINGLES, 16'h0001, 16'h0001, 16'h0001);
        send_request(REQ_HEADER, FC_ALL_ONES, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_coil_write();
        logic [15:0] coils [9] = '{16'h0001, 16'h0000, 16'h8000, 16'h0000, 16'hFFFF,
                                   16'h0000, 16'h0000, 16'h0100, 16'h0001};
        // Nine coils: one full byte, then a one-coil partial byte.
        send_request(REQ_HEADER, FC_WRITE_COILS, 16'h0013, 16'd9, 16'h0000);
        foreach (coils[i])
            send_value(coils[i]);
    endtask

    task automatic test_register_write();
        send_request(REQ_HEADER, FC_WRITE_REGS, 16'h0001, 16'd2, 16'h0000);
        send_value(16'hFFFF);
        send_value(16'h0001);
    endtask

    task automatic test_bad_write_counts();
        send_request(REQ_HEADER, FC_WRITE_REGS, 16'h0000, 16'(MAX_WRITE_VALUES + 1),
                     16'h0000);
        send_request(REQ_HEADER, FC_WRITE_COILS, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_stray_value();
        send_value(16'h0005);
    endtask

    task automatic test_abandoned_write();
        // The second header ends the coil write with an error; the value
        // request after it then finds the block idle.
        send_write_sequence(FC_WRITE_COILS, 3, 1);
        send_request(REQ_HEADER, FC_READ_COILS, 16'h0000, 16'h0008, 16'h0000);
        send_value(16'h0001);
    endtask

    task automatic test_random_traffic();
        int          target;
        int          pick;
        int          count;
        logic [7:0]  code;
        logic [15:0] addr;
        target = requests_sent + RANDOM_REQUESTS;
        // One write at the largest allowed size, random code and content.
        send_write_sequence($urandom_range(0, 1) ? FC_WRITE_COILS : FC_WRITE_REGS,
                            MAX_WRITE_VALUES, MAX_WRITE_VALUES);
        while (requests_sent < target)
        begin
            pick = $urandom_range(0, 99);
            addr = 16'($urandom);
            if (pick < 50)
            begin
                // Well-formed multiple writes, a tenth of them cut short.
                code  = $urandom_range(0, 1) ? FC_WRITE_COILS : FC_WRITE_REGS;
                count = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 60)
                                                    : $urandom_range(1, 20);
                send_write_sequence(code, count,
                                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, count - 1)
                                                                : count);
            end
            else if (pick < 70)
            begin
                code  = 8'($urandom_range(FC_FIRST_SUPPORTED, FC_LAST_SINGLE));
                count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 16'hFFFF);
                send_request(REQ_HEADER, code, addr, 16'(count), 16'($urandom));
            end
            else if (pick < 78)
            begin
                do
                    code = 8'($urandom_range(0, 255));
                while ((code >= FC_FIRST_SUPPORTED && code <= FC_LAST_SINGLE)
                       || code == FC_WRITE_COILS || code == FC_WRITE_REGS);
                send_request(REQ_HEADER, code, addr, 16'($urandom), 16'($urandom));
            end
            else if (pick < 86)
            begin
                // Zero or oversized counts on the multiple writes.
                code = $urandom_range(0, 1) ? FC_WRITE_COILS : FC_WRITE_REGS;
                case ($urandom_range(0, 2))
                    0:       count = 0;
                    1:       count = MAX_WRITE_VALUES + 1;
                    default: count = $urandom_range(MAX_WRITE_VALUES + 1, 16'hFFFF);
                endcase
                send_request(REQ_HEADER, code, addr, 16'(count), 16'($urandom));
            end
            else if (pick < 93)
            begin
                send_value(16'($urandom));
            end
            else
            begin
                send_request(REQ_HEADER, 8'($urandom_range(0, 255)), addr,
                             16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_read_requests();
        test_single_writes();
        test_unknown_codes();
        test_coil_write();
        test_register_write();
        test_bad_write_counts();
        test_stray_value();
        test_abandoned_write();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pending_pdu_bytes.size() != 0)
            @(posedge clk);
        // Extra cycles catch any byte the block sends beyond the prediction.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (byte_mismatches == 0 && pending_pdu_bytes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
